// File: rtl/indexed_binary_min_heap_defines.svh
// ---------------------------------------------------------------------------
// Indexed binary min-heap assertion macros
// Shared concurrent assertion wrappers; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef INDEXED_BINARY_MIN_HEAP_DEFINES_SVH
`define INDEXED_BINARY_MIN_HEAP_DEFINES_SVH
`ifndef SYNTHESIS
`define IBH_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("heap check failed");
`define IBH_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("heap check failed");
`else
`define IBH_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define IBH_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

// File: rtl/ibh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed binary min-heap package
// Item types, operation and status codes, sizes.
// ---------------------------------------------------------------------------
package ibh_pkg;

   localparam int CAPACITY = 256;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_FIND   = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;
   localparam logic [1:0] ST_DUP    = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  handle;
      logic [31:0] key;
      logic [7:0]  index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  found_handle;
      logic [31:0] found_key;
      logic [8:0]  entry_count;
      logic        moved;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  handle;
      logic [31:0] key;
   } entry_type;

endpackage

// File: rtl/indexed_binary_min_heap.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed binary min-heap
// Heap of (handle, key) entries with handle-to-position lookup.
// ---------------------------------------------------------------------------
// Usage: one request item (insert, remove, update key, find) enters on the
// req channel; exactly one response item leaves on the rsp channel.
// One item is worked at a time: req_stall is high from acceptance until the
// response is loaded into the output register. The response register lets
// the next item be accepted while a result still waits on a stalled rsp.
// A rejected item goes straight to the response, and find reads one entry.
// Insert climbs from the new last position. Remove and update add a
// position lookup (and, for remove, a fetch of the last entry), then climb
// or sink one level at a time, with a read state and a compare state per
// level. The response is registered: it is valid in the cycle after the
// S_RESP state loads it.
// Reset clears the entry count and the presence bits at once; the memories
// hold no reset value and need no clearing pass.
// If rsp_stall stays high, a second finished result waits in the block and
// no further item is accepted.
// ---------------------------------------------------------------------------
`include "indexed_binary_min_heap_defines.svh"

module indexed_binary_min_heap
   import ibh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_POS_RD  = 9'b000000010,
      S_LAST_RD = 9'b000000100,
      S_FIND_RD = 9'b000001000,
      S_BU_RD   = 9'b000010000,
      S_BU_CMP  = 9'b000100000,
      S_SK_RD   = 9'b001000000,
      S_SK_CMP  = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

   state_type    state_ff, state_in;
   logic [1:0]   op_ff, op_in;
   logic [7:0]   hnd_ff, hnd_in;
   logic [31:0]  key_ff, key_in;
   entry_type    ent_ff, ent_in;
   logic [7:0]   pos_ff, pos_in;
   logic         reloc_ff, reloc_in;
   logic         bu_moved_ff, bu_moved_in;
   logic         moved_ff, moved_in;
   logic [1:0]   status_ff, status_in;
   entry_type    found_ff, found_in;
   logic [8:0]   count_ff, count_in;
   logic [255:0] present_ff, present_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   entry_type    heap_mem [CAPACITY];
   logic [7:0]   pos_mem [CAPACITY];
   entry_type    heap_ra_ff, heap_rb_ff;
   logic [7:0]   pos_rd_ff;

   logic         heap_we, pos_we;
   logic [7:0]   heap_wa, pos_wa, pos_wd;
   entry_type    heap_wd;
   logic [7:0]   heap_ra, heap_rb, pos_ra;

   logic [7:0]   above_pos;
   logic [8:0]   left_pos;
   logic [9:0]   right_idx;
   logic         take_right;
   entry_type    child_ent;
   logic [8:0]   last_idx;
   logic         rsp_free;

   // Heap and position memories with registered reads
   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[heap_wa] <= heap_wd;
      end
      if (pos_we) begin
         pos_mem[pos_wa] <= pos_wd;
      end
      heap_ra_ff <= heap_mem[heap_ra];
      heap_rb_ff <= heap_mem[heap_rb];
      pos_rd_ff  <= pos_mem[pos_ra];
   end

   // Tree neighbors of the current position
   assign above_pos  = (pos_ff - 8'd1) >> 1;
   assign left_pos   = {pos_ff, 1'b1};
   assign right_idx  = {1'b0, left_pos} + 10'd1;
   assign take_right = (right_idx < {1'b0, count_ff}) && (heap_rb_ff.key <= heap_ra_ff.key);
   assign child_ent  = take_right ? heap_rb_ff : heap_ra_ff;
   assign last_idx   = count_ff - 9'd1;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Sequencer: lookup, climb, sink, respond
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hnd_in       = hnd_ff;
      key_in       = key_ff;
      ent_in       = ent_ff;
      pos_in       = pos_ff;
      reloc_in     = reloc_ff;
      bu_moved_in  = bu_moved_ff;
      moved_in     = moved_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      present_in   = present_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      heap_we      = 1'b0;
      heap_wa      = pos_ff;
      heap_wd      = ent_ff;
      pos_we       = 1'b0;
      pos_wa       = ent_ff.handle;
      pos_wd       = pos_ff;
      heap_ra      = req.index;
      heap_rb      = req.index;
      pos_ra       = req.handle;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req.op;
               hnd_in      = req.handle;
               key_in      = req.key;
               status_in   = ST_OK;
               found_in    = '0;
               moved_in    = 1'b0;
               bu_moved_in = 1'b0;
               reloc_in    = 1'b0;
               unique case (req.op)
                  OP_INSERT: begin
                     if (count_ff == 9'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else if (present_ff[req.handle]) begin
                        status_in = ST_DUP;
                        state_in  = S_RESP;
                     end else begin
                        ent_in                 = '{handle: req.handle, key: req.key};
                        pos_in                 = count_ff[7:0];
                        count_in               = count_ff + 9'd1;
                        present_in[req.handle] = 1'b1;
                        state_in               = S_BU_RD;
                     end
                  end
                  OP_REMOVE, OP_UPDATE: begin
                     if (!present_ff[req.handle]) begin
                        status_in = ST_ABSENT;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_POS_RD;
                     end
                  end
                  OP_FIND: begin
                     if ({1'b0, req.index} >= count_ff) begin
                        status_in = ST_ABSENT;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_POS_RD: begin
            if ({1'b0, pos_rd_ff} >= count_ff) begin
               status_in = ST_ABSENT;
               state_in  = S_RESP;
            end else if (op_ff == OP_REMOVE) begin
               count_in             = last_idx;
               present_in[hnd_ff]   = 1'b0;
               pos_in               = pos_rd_ff;
               heap_ra              = last_idx[7:0];
               state_in             = (pos_rd_ff == last_idx[7:0]) ? S_RESP : S_LAST_RD;
            end else begin
               ent_in   = '{handle: hnd_ff, key: key_ff};
               pos_in   = pos_rd_ff;
               reloc_in = 1'b1;
               state_in = S_BU_RD;
            end
         end
         S_LAST_RD: begin
            ent_in   = heap_ra_ff;
            moved_in = 1'b1;
            reloc_in = 1'b1;
            state_in = S_BU_RD;
         end
         S_FIND_RD: begin
            found_in = heap_ra_ff;
            state_in = S_RESP;
         end
         S_BU_RD: begin
            heap_ra = above_pos;
            if (pos_ff == 8'd0) begin
               heap_we  = 1'b1;
               pos_we   = 1'b1;
               state_in = (reloc_ff && !bu_moved_ff) ? S_SK_RD : S_RESP;
            end else begin
               state_in = S_BU_CMP;
            end
         end
         S_BU_CMP: begin
            if (heap_ra_ff.key <= ent_ff.key) begin
               // Stop: drop the entry into its place
               heap_we  = 1'b1;
               pos_we   = 1'b1;
               state_in = (reloc_ff && !bu_moved_ff) ? S_SK_RD : S_RESP;
            end else begin
               // Move the parent down one level
               heap_we     = 1'b1;
               heap_wd     = heap_ra_ff;
               pos_we      = 1'b1;
               pos_wa      = heap_ra_ff.handle;
               pos_in      = above_pos;
               bu_moved_in = 1'b1;
               moved_in    = 1'b1;
               state_in    = S_BU_RD;
            end
         end
         S_SK_RD: begin
            heap_ra = left_pos[7:0];
            heap_rb = left_pos[7:0] + 8'd1;
            if (left_pos >= count_ff) begin
               heap_we  = 1'b1;
               pos_we   = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_SK_CMP;
            end
         end
         S_SK_CMP: begin
            if (ent_ff.key <= child_ent.key) begin
               heap_we  = 1'b1;
               pos_we   = 1'b1;
               state_in = S_RESP;
            end else begin
               // Move the smaller child up one level
               heap_we  = 1'b1;
               heap_wd  = child_ent;
               pos_we   = 1'b1;
               pos_wa   = child_ent.handle;
               pos_in   = take_right ? right_idx[7:0] : left_pos[7:0];
               moved_in = 1'b1;
               state_in = S_SK_RD;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: status_ff, found_handle: found_ff.handle,
                                found_key: found_ff.key, entry_count: count_ff,
                                moved: moved_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      hnd_ff      <= hnd_in;
      key_ff      <= key_in;
      ent_ff      <= ent_in;
      pos_ff      <= pos_in;
      reloc_ff    <= reloc_in;
      bu_moved_ff <= bu_moved_in;
      moved_ff    <= moved_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `IBH_ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= 9'(CAPACITY))
   `IBH_ASSERT_IMPLIES(a_climb_in_range, clock, reset, state_ff == S_BU_CMP, {1'b0, pos_ff} < count_ff)
   `IBH_ASSERT_NEXT(a_resp_loaded, clock, reset, state_ff == S_RESP && rsp_free, rsp_valid_ff && state_ff == S_IDLE)

endmodule
